// ===== design/its_pkg.sv =====
// ----------------------------------------------------------------------------
// its_pkg
// Shared types, opcodes and the control program of the interval timing
// statistics block.
// ----------------------------------------------------------------------------
package its_pkg;

  // commands carried by an input item
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_END   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [63:0] ALL_ONES64 = '1;

  // program counter and step addresses
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] PC_FETCH   = 3'd0;
  localparam logic [PC_W-1:0] PC_DIFF    = 3'd1;
  localparam logic [PC_W-1:0] PC_UPDATE  = 3'd2;
  localparam logic [PC_W-1:0] PC_DIVINIT = 3'd3;
  localparam logic [PC_W-1:0] PC_DIVSTEP = 3'd4;
  localparam logic [PC_W-1:0] PC_WAIT    = 3'd5;
  localparam logic [PC_W-1:0] PC_EMIT    = 3'd6;

  // datapath operations
  typedef enum logic [2:0] {
    OP_FETCH,
    OP_DIFF,
    OP_UPDATE,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_WAIT,
    OP_EMIT
  } op_t;

  // jump conditions, the jump is taken when the condition holds
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_IN,
    COND_COUNT_ZERO,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // control handed to the datapath
  typedef struct packed {
    op_t op;
  } ctrl_t;

  // status returned to the sequencer
  typedef struct packed {
    logic in_valid;
    logic count_zero;
    logic div_more;
    logic out_busy;
  } stat_t;

  // control program
  function automatic uword_t its_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      PC_FETCH:   w = '{op: OP_FETCH,   cond: COND_NO_IN,      target: PC_FETCH};
      PC_DIFF:    w = '{op: OP_DIFF,    cond: COND_NEVER,      target: PC_FETCH};
      PC_UPDATE:  w = '{op: OP_UPDATE,  cond: COND_NEVER,      target: PC_FETCH};
      PC_DIVINIT: w = '{op: OP_DIVINIT, cond: COND_COUNT_ZERO, target: PC_WAIT};
      PC_DIVSTEP: w = '{op: OP_DIVSTEP, cond: COND_DIV_MORE,   target: PC_DIVSTEP};
      PC_WAIT:    w = '{op: OP_WAIT,    cond: COND_OUT_BUSY,   target: PC_WAIT};
      PC_EMIT:    w = '{op: OP_EMIT,    cond: COND_ALWAYS,     target: PC_FETCH};
      default:    w = '{op: OP_WAIT,    cond: COND_ALWAYS,     target: PC_FETCH};
    endcase
    return w;
  endfunction

endpackage

// ===== design/its_in_if.sv =====
// ----------------------------------------------------------------------------
// its_in_if
// Input channel: one command and timestamp per item.
// ----------------------------------------------------------------------------
interface its_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] timestamp;

  modport source (output valid, output cmd, output timestamp, input ready);
  modport sink   (input valid, input cmd, input timestamp, output ready);
endinterface

// ===== design/its_out_if.sv =====
// ----------------------------------------------------------------------------
// its_out_if
// Result channel: statistics after each item.
// ----------------------------------------------------------------------------
interface its_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] last_sample;
  logic [63:0] average;
  logic [63:0] minimum;
  logic [63:0] maximum;
  logic [31:0] sample_count;

  modport source (output valid, output last_sample, output average, output minimum,
                  output maximum, output sample_count, input ready);
  modport sink   (input valid, input last_sample, input average, input minimum,
                  input maximum, input sample_count, output ready);
endinterface

// ===== design/its_seq.sv =====
// ----------------------------------------------------------------------------
// its_seq
// Step counter and control store; issues one control word per cycle and
// resolves conditional jumps from datapath status.
// ----------------------------------------------------------------------------
module its_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  its_pkg::stat_t stat,
  output its_pkg::ctrl_t ctrl
);
  import its_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  uword_t          word;
  logic            take;

  // fetch the control word and evaluate its jump condition
  always_comb begin
    word = its_rom(pc_r);
    case (word.cond)
      COND_NEVER:      take = 1'b0;
      COND_ALWAYS:     take = 1'b1;
      COND_NO_IN:      take = !stat.in_valid;
      COND_COUNT_ZERO: take = stat.count_zero;
      COND_DIV_MORE:   take = stat.div_more;
      COND_OUT_BUSY:   take = stat.out_busy;
      default:         take = 1'b1;
    endcase
    pc_nxt  = take ? word.target : pc_r + 1'b1;
    ctrl.op = word.op;
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== design/interval_timing_statistics_core.sv =====
// ----------------------------------------------------------------------------
// interval_timing_statistics_core
// Interval measurement with running minimum, maximum and mean.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command (start, end, clear) and a 64-bit timestamp per
//   item; out_ch returns one result item per input item holding the reference
//   (the last interval after an end), the mean, the minimum, the maximum and
//   the sample count as they stand after that item. Both channels move an
//   item when valid and ready are high at a rising edge.
//   The mean comes from a radix-2 restoring divider that retires one
//   quotient bit per cycle over 64 steps; the divider is skipped when the
//   count is zero. One item is processed at a time: no new item is accepted
//   until the current one has been emitted.
//   The result sits in an output register; a new item is accepted while it
//   waits. If the receiver stalls, the next result holds in the wait step
//   and no further item is accepted until the register frees.
//   Reset: synchronous active-low rst_n; reference and statistics return to
//   their cleared values (minimum all ones) and no result is pending.
// ----------------------------------------------------------------------------
module interval_timing_statistics_core (
  input logic  clk,
  input logic  rst_n,
  its_in_if.sink    in_ch,
  its_out_if.source out_ch
);
  import its_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // captured item
  logic [1:0]  cmd_r, cmd_nxt;
  logic [63:0] ts_r, ts_nxt;
  logic [63:0] delta_r, delta_nxt;

  // statistics state
  logic [63:0] ref_r, ref_nxt;
  logic [63:0] min_r, min_nxt;
  logic [63:0] max_r, max_nxt;
  logic [63:0] total_r, total_nxt;
  logic [31:0] cnt_r, cnt_nxt;

  // divider
  logic [63:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [5:0]  iter_r, iter_nxt;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        rem_ge;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] o_last_r, o_last_nxt;
  logic [63:0] o_avg_r, o_avg_nxt;
  logic [63:0] o_min_r, o_min_nxt;
  logic [63:0] o_max_r, o_max_nxt;
  logic [31:0] o_cnt_r, o_cnt_nxt;

  logic in_fire;
  logic count_zero;

  its_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  assign in_ch.ready = (ctrl.op == OP_FETCH);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign count_zero  = (cnt_r == 32'd0);

  // status for the sequencer
  assign stat.in_valid   = in_ch.valid;
  assign stat.count_zero = count_zero;
  assign stat.div_more   = (iter_r != 6'h3f);
  assign stat.out_busy   = out_valid_r && !out_ch.ready;

  // one restoring division step
  assign rem_sh  = {rem_r, quo_r[63]};
  assign rem_ge  = (rem_sh >= {1'b0, cnt_r});
  assign rem_sub = rem_sh - {1'b0, cnt_r};

  // datapath next state under the current control word
  always_comb begin
    cmd_nxt   = cmd_r;
    ts_nxt    = ts_r;
    delta_nxt = delta_r;
    ref_nxt   = ref_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    total_nxt = total_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    iter_nxt  = iter_r;
    o_last_nxt = o_last_r;
    o_avg_nxt  = o_avg_r;
    o_min_nxt  = o_min_r;
    o_max_nxt  = o_max_r;
    o_cnt_nxt  = o_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (ctrl.op)
      OP_FETCH: begin
        if (in_fire) begin
          cmd_nxt = in_ch.cmd;
          ts_nxt  = in_ch.timestamp;
        end
      end
      OP_DIFF: begin
        delta_nxt = ts_r - ref_r;
      end
      OP_UPDATE: begin
        case (cmd_r)
          CMD_START: begin
            ref_nxt = ts_r;
          end
          CMD_END: begin
            ref_nxt   = delta_r;
            if (delta_r < min_r) min_nxt = delta_r;
            if (delta_r > max_r) max_nxt = delta_r;
            total_nxt = total_r + delta_r;
            cnt_nxt   = cnt_r + 32'd1;
          end
          CMD_CLEAR: begin
            min_nxt   = ALL_ONES64;
            max_nxt   = '0;
            total_nxt = '0;
            cnt_nxt   = '0;
          end
          default: begin
          end
        endcase
      end
      OP_DIVINIT: begin
        quo_nxt  = total_r;
        rem_nxt  = '0;
        iter_nxt = '0;
      end
      OP_DIVSTEP: begin
        rem_nxt  = rem_ge ? rem_sub[31:0] : rem_sh[31:0];
        quo_nxt  = {quo_r[62:0], rem_ge};
        iter_nxt = iter_r + 6'd1;
      end
      OP_EMIT: begin
        out_valid_nxt = 1'b1;
        o_last_nxt = count_zero ? '0 : ref_r;
        o_avg_nxt  = count_zero ? '0 : quo_r;
        o_min_nxt  = count_zero ? '0 : min_r;
        o_max_nxt  = count_zero ? '0 : max_r;
        o_cnt_nxt  = cnt_r;
      end
      default: begin
      end
    endcase
  end

  // state and statistics registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r       <= '0;
      min_r       <= ALL_ONES64;
      max_r       <= '0;
      total_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ref_r       <= ref_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      total_r     <= total_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    ts_r     <= ts_nxt;
    delta_r  <= delta_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    iter_r   <= iter_nxt;
    o_last_r <= o_last_nxt;
    o_avg_r  <= o_avg_nxt;
    o_min_r  <= o_min_nxt;
    o_max_r  <= o_max_nxt;
    o_cnt_r  <= o_cnt_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.last_sample  = o_last_r;
  assign out_ch.average      = o_avg_r;
  assign out_ch.minimum      = o_min_r;
  assign out_ch.maximum      = o_max_r;
  assign out_ch.sample_count = o_cnt_r;

  // an accepted item is worked on alone
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("item accepted while another is in progress");

  // the divider never runs with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_DIVSTEP) |-> !count_zero)
    else $error("division step with zero count");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_EMIT) |-> (!out_valid_r || out_ch.ready))
    else $error("result emitted over a pending one");

  // the mean never exceeds the total
  a_avg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_EMIT) && !count_zero |-> (quo_r <= total_r))
    else $error("average larger than total");

  // an empty count reports zero statistics
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (o_cnt_r == 32'd0) |-> (o_avg_r == 64'd0) && (o_min_r == 64'd0)
      && (o_max_r == 64'd0) && (o_last_r == 64'd0))
    else $error("nonzero statistics with zero count");

endmodule

// ===== tb/interval_timing_statistics_core_tb.sv =====
// ----------------------------------------------------------------------------
// interval_timing_statistics_core_tb
// Drives start, end, clear and unused commands into the interval statistics
// core and checks every result item against a running model of the reference
// register, min, max, wrapping total and wrapping count. Both channels idle
// and stall at random, with stretches of full rate.
// ----------------------------------------------------------------------------
module interval_timing_statistics_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import its_pkg::*;

  // unused command code, changes no state
  localparam logic [1:0] CMD_NOP = 2'd3;

  localparam int RANDOM_ITEMS = 1450;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] ts;
  } mark_t;

  typedef struct packed {
    logic [63:0] last_sample;
    logic [63:0] average;
    logic [63:0] minimum;
    logic [63:0] maximum;
    logic [31:0] sample_count;
  } stats_t;

  logic clk;
  logic rst_n;

  its_in_if  in_ch ();
  its_out_if out_ch ();

  interval_timing_statistics_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // marks waiting to be sent and statistics waiting to come back
  mark_t  mark_q[$];
  stats_t stats_q[$];
  int     errors = 0;
  int     cycles = 0;

  // model state
  logic [63:0] held_ref    = '0;
  logic [63:0] shortest    = ALL_ONES64;
  logic [63:0] longest     = '0;
  logic [63:0] total_ticks = '0;
  logic [31:0] n_intervals = '0;

  // apply one mark to the model and return the statistics it reports
  function automatic stats_t apply_mark(logic [1:0] cmd, logic [63:0] ts);
    stats_t      r;
    logic [63:0] d;
    case (cmd)
      CMD_START: begin
        held_ref = ts;
      end
      CMD_END: begin
        d = ts - held_ref;
        held_ref = d;
        if (d < shortest) shortest = d;
        if (d > longest) longest = d;
        total_ticks = total_ticks + d;
        n_intervals = n_intervals + 32'd1;
      end
      CMD_CLEAR: begin
        n_intervals = '0;
        total_ticks = '0;
        longest     = '0;
        shortest    = ALL_ONES64;
      end
      default: begin
      end
    endcase
    r = '0;
    if (n_intervals != 0) begin
      r.last_sample = held_ref;
      r.average     = total_ticks / {32'd0, n_intervals};
      r.minimum     = shortest;
      r.maximum     = longest;
    end
    r.sample_count = n_intervals;
    return r;
  endfunction

  task automatic add_mark(logic [1:0] cmd, logic [63:0] ts);
    mark_t m;
    m.cmd = cmd;
    m.ts  = ts;
    mark_q.push_back(m);
  endtask

  // interval length: mostly short, some 32-bit, a few full width
  function automatic logic [63:0] rand_interval();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 64'($urandom_range(0, 5000));
    if (sel < 9) return {32'd0, $urandom};
    return {$urandom, $urandom};
  endfunction

  // small timestamp for a stray end, so the delta against an old interval
  // stays small some of the time
  function automatic logic [63:0] held_hint(logic [63:0] dt);
    return dt & 64'h0000_0000_000F_FFFF;
  endfunction

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // input driver
  int    in_gap;
  int    in_gap_now;
  bit    in_quiet = 1'b0;
  mark_t next_mark;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap      <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        // item accepted: predict and draw the gap before the next one
        stats_q.push_back(apply_mark(in_ch.cmd, in_ch.timestamp));
        if ($urandom_range(0, 49) == 0) in_quiet = !in_quiet;
        in_gap_now = in_quiet ? 0 : $urandom_range(0, 19);
      end else begin
        in_gap_now = in_gap;
      end
      if (in_gap_now == 0 && mark_q.size() != 0) begin
        next_mark = mark_q.pop_front();
        in_ch.cmd       <= next_mark.cmd;
        in_ch.timestamp <= next_mark.ts;
        in_ch.valid     <= 1'b1;
        in_gap          <= 0;
      end else begin
        in_ch.valid <= 1'b0;
        in_gap      <= (in_gap_now == 0) ? 0 : in_gap_now - 1;
      end
    end
  end

  // result monitor
  int     out_stall;
  int     out_stall_now;
  bit     out_quiet = 1'b0;
  stats_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (stats_q.size() == 0) begin
          $error("result item with no expectation pending");
          errors++;
        end else begin
          want = stats_q.pop_front();
          compare_field("last_sample", want.last_sample, out_ch.last_sample);
          compare_field("average", want.average, out_ch.average);
          compare_field("minimum", want.minimum, out_ch.minimum);
          compare_field("maximum", want.maximum, out_ch.maximum);
          compare_field("sample_count", {32'd0, want.sample_count},
                        {32'd0, out_ch.sample_count});
        end
        // stall before taking the next item
        if ($urandom_range(0, 49) == 0) out_quiet = !out_quiet;
        out_stall_now = out_quiet ? 0 : $urandom_range(0, 19);
        out_ch.ready <= (out_stall_now == 0);
        out_stall    <= (out_stall_now == 0) ? 0 : out_stall_now - 1;
      end else if (!out_ch.ready) begin
        if (out_stall == 0) out_ch.ready <= 1'b1;
        else out_stall <= out_stall - 1;
      end
    end
  end

  // stimulus, reset and end of run
  int          n_random;
  int          pick;
  logic [63:0] t0;
  logic [63:0] dt;

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_START;
    in_ch.timestamp = '0;
    out_ch.ready    = 1'b0;

    // directed: empty statistics, wraps, extremes, end without start, clear
    add_mark(CMD_NOP, ALL_ONES64);
    add_mark(CMD_CLEAR, ALL_ONES64);
    add_mark(CMD_END, 64'd0);
    add_mark(CMD_START, 64'hFFFF_FFFF_FFFF_FFF0);
    add_mark(CMD_END, 64'h0000_0000_0000_0010);
    add_mark(CMD_START, 64'd0);
    add_mark(CMD_END, ALL_ONES64);
    add_mark(CMD_END, 64'd5);
    add_mark(CMD_NOP, 64'd0);
    add_mark(CMD_START, 64'h5555_5555_5555_5555);
    add_mark(CMD_END, 64'hAAAA_AAAA_AAAA_AAAA);
    add_mark(CMD_CLEAR, 64'd0);
    add_mark(CMD_NOP, 64'h1234_5678_9ABC_DEF0);
    add_mark(CMD_END, 64'hAAAA_AAAA_AAAA_AAAA);
    add_mark(CMD_START, 64'd1);
    add_mark(CMD_END, 64'd1);
    add_mark(CMD_START, ALL_ONES64);
    add_mark(CMD_END, ALL_ONES64 - 64'd1);
    add_mark(CMD_START, {$urandom, $urandom});
    add_mark(CMD_END, {$urandom, $urandom});
    add_mark(CMD_CLEAR, {$urandom, $urandom});
    add_mark(CMD_START, 64'h8000_0000_0000_0000);
    add_mark(CMD_END, 64'h8000_0000_0000_0007);

    // random: mostly start/end pairs, some stray ends, starts, clears, nops
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      t0   = {$urandom, $urandom};
      dt   = rand_interval();
      if (pick < 68) begin
        add_mark(CMD_START, t0);
        add_mark(CMD_END, t0 + dt);
        n_random += 2;
      end else if (pick < 78) begin
        add_mark(CMD_END, ($urandom_range(0, 1) == 0) ? t0 : held_hint(dt));
        n_random += 1;
      end else if (pick < 85) begin
        add_mark(CMD_START, t0);
        n_random += 1;
      end else if (pick < 89) begin
        add_mark(CMD_CLEAR, t0);
        n_random += 1;
      end else if (pick < 94) begin
        add_mark(CMD_NOP, t0);
        n_random += 1;
      end else begin
        add_mark(CMD_START, {$urandom, $urandom});
        add_mark(CMD_START, t0);
        add_mark(CMD_END, t0 + dt);
        n_random += 3;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // drain
    do @(posedge clk);
    while (mark_q.size() != 0 || in_ch.valid || stats_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
